// File: src/abl_pkg.sv
// ----------------------------------------------------------------------------
// abl_pkg: shared types and constants of the bass level tracker
// Payload structs, controller command and status types, fixed-point constants
// and the elaboration-time filter coefficient function.
// ----------------------------------------------------------------------------
`default_nettype none

package abl_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SELECT = 2'd2;

  // Register reset values and clamp limits.
  localparam logic [11:0] SENS_RESET = 12'd512;
  localparam logic [11:0] SENS_MIN   = 12'd26;
  localparam logic [11:0] SENS_MAX   = 12'd2560;
  localparam logic [15:0] SMOOTH_RESET = 16'd53740;
  localparam logic [15:0] SMOOTH_MAX   = 16'd64225;

  // Range tracker constants, Q0.24 values and Q0.32 weights.
  localparam logic [24:0] FLOOR_RESET = 25'd33554;
  localparam logic [24:0] CEIL_RESET  = 25'd1006633;
  localparam logic [24:0] MIN_SPAN    = 25'd67109;
  localparam logic [23:0] RMS_MAX     = 24'd16777215;
  localparam logic [23:0] CEIL_W      = 24'd8589935;
  localparam logic [31:0] CEIL_KEEP   = 32'd4286377361;
  localparam logic [23:0] FLOOR_W     = 24'd2147484;
  localparam logic [31:0] FLOOR_KEEP  = 32'd4292819812;

  // Divider geometry: quotient width and per-division shift counts.
  localparam int QUO_W = 49;
  localparam int DEN_W = 25;
  localparam logic [5:0] DIV1_SHIFT = 6'd48;
  localparam logic [5:0] NORM_SHIFT = 6'd16;

  // 2*pi in Q34.30 for the coefficient computation.
  localparam logic [63:0] Q30_TWO_PI = 64'd6746518852;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } abl_in_t;

  typedef struct packed {
    logic [15:0] level;
    logic [15:0] peak_smoothed;
    logic [15:0] bass_smoothed;
    logic [23:0] block_bass_rms;
  } abl_out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FLO,
    OP_FHI,
    OP_FUPD,
    OP_BASS,
    OP_SQ,
    OP_ACC,
    OP_DIV1_START,
    OP_SQRT_START,
    OP_SQRT_STEP,
    OP_RANGE_MUL,
    OP_RANGE_UPD,
    OP_SPAN,
    OP_NORM_START,
    OP_BLEND_MUL,
    OP_BLEND_UPD,
    OP_LVL_MUL,
    OP_OUT_LOAD
  } abl_op_t;

  typedef struct packed {
    abl_op_t op;
  } abl_cmd_t;

  typedef struct packed {
    logic close;
    logic div_done;
    logic sqrt_last;
  } abl_stat_t;

  // One-pole coefficient 1 - exp(-x) in Q0.30 from a truncated series.
  function automatic logic [63:0] q30_coeff(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] s;
    x = (x_in > 64'h1_0000_0000) ? 64'h1_0000_0000 : x_in;
    t = x;
    s = x;
    for (int k = 2; k <= 12; k++) begin
      t = (t * x / 64'(k)) >> 30;
      if ((k & 1) != 0) begin
        s = s + t;
      end else begin
        s = s - t;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: src/abl_div.sv
// ----------------------------------------------------------------------------
// abl_div: shift-subtract divider
// Restoring division, one quotient bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module abl_div #(
  parameter int NUM_W = 62
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [NUM_W-1:0]          num,
  input  wire logic [abl_pkg::DEN_W-1:0] den,
  input  wire logic [5:0]                shift,
  output logic [abl_pkg::QUO_W-1:0]      quo,
  output logic                           done
);
  import abl_pkg::*;

  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             ge;

  assign ge = (rem_r >= dsh_r);

  // Control: busy while bits remain, done pulses after the last bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= shift;
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  // Datapath: compare, subtract and shift in one quotient bit.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= NUM_W'(den) << shift;
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

`default_nettype wire

// File: src/abl_ctrl.sv
// ----------------------------------------------------------------------------
// abl_ctrl: sequencer of the bass level tracker
// Steps the datapath through the per-sample filter work and, at the end of a
// block, through division, root, range update, smoothing and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module abl_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire abl_pkg::abl_stat_t  stat,
  output abl_pkg::abl_cmd_t        cmd
);
  import abl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_FLO, S_FHI, S_FUPD, S_BASS, S_SQ, S_ACC,
    S_DIV1_GO, S_DIV1_WAIT, S_SQRT_GO, S_SQRT,
    S_RANGE_MUL, S_RANGE_UPD, S_SPAN, S_NORM_GO, S_NORM_WAIT,
    S_BLEND_MUL, S_BLEND_UPD, S_LVL_MUL, S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   emit_ok;

  // The result register is free when empty or being emptied this cycle.
  assign emit_ok = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_FLO;
      S_FLO:       state_nxt = S_FHI;
      S_FHI:       state_nxt = S_FUPD;
      S_FUPD:      state_nxt = S_BASS;
      S_BASS:      state_nxt = S_SQ;
      S_SQ:        state_nxt = S_ACC;
      S_ACC:       state_nxt = stat.close ? S_DIV1_GO : S_IDLE;
      S_DIV1_GO:   state_nxt = S_DIV1_WAIT;
      S_DIV1_WAIT: if (stat.div_done) state_nxt = S_SQRT_GO;
      S_SQRT_GO:   state_nxt = S_SQRT;
      S_SQRT:      if (stat.sqrt_last) state_nxt = S_RANGE_MUL;
      S_RANGE_MUL: state_nxt = S_RANGE_UPD;
      S_RANGE_UPD: state_nxt = S_SPAN;
      S_SPAN:      state_nxt = S_NORM_GO;
      S_NORM_GO:   state_nxt = S_NORM_WAIT;
      S_NORM_WAIT: if (stat.div_done) state_nxt = S_BLEND_MUL;
      S_BLEND_MUL: state_nxt = S_BLEND_UPD;
      S_BLEND_UPD: state_nxt = S_LVL_MUL;
      S_LVL_MUL:   state_nxt = S_EMIT;
      S_EMIT:      if (emit_ok) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Command to the datapath for the current state.
  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_FLO:       cmd.op = OP_FLO;
      S_FHI:       cmd.op = OP_FHI;
      S_FUPD:      cmd.op = OP_FUPD;
      S_BASS:      cmd.op = OP_BASS;
      S_SQ:        cmd.op = OP_SQ;
      S_ACC:       cmd.op = OP_ACC;
      S_DIV1_GO:   cmd.op = OP_DIV1_START;
      S_SQRT_GO:   cmd.op = OP_SQRT_START;
      S_SQRT:      cmd.op = OP_SQRT_STEP;
      S_RANGE_MUL: cmd.op = OP_RANGE_MUL;
      S_RANGE_UPD: cmd.op = OP_RANGE_UPD;
      S_SPAN:      cmd.op = OP_SPAN;
      S_NORM_GO:   cmd.op = OP_NORM_START;
      S_BLEND_MUL: cmd.op = OP_BLEND_MUL;
      S_BLEND_UPD: cmd.op = OP_BLEND_UPD;
      S_LVL_MUL:   cmd.op = OP_LVL_MUL;
      S_EMIT:      cmd.op = emit_ok ? OP_OUT_LOAD : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // The divider only finishes while the sequencer is waiting on it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == S_DIV1_WAIT || state_r == S_NORM_WAIT))
    else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

// File: src/abl_dp.sv
// ----------------------------------------------------------------------------
// abl_dp: datapath of the bass level tracker
// Filters, block accumulators, root, range tracker, smoothing and the result
// register, stepped by commands from the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module abl_dp #(
  parameter int          MAX_BLOCK = 4096,
  parameter int          CNT_W     = 13,
  parameter int          SUM_W     = 43,
  parameter int          DIVN_W    = 61,
  parameter logic [30:0] A_SLOW    = 31'd5639622,
  parameter logic [30:0] A_FAST    = 31'd25229063
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire abl_pkg::abl_in_t                  in_data,
  input  wire logic                              cfg_we,
  input  wire logic [abl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [abl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire abl_pkg::abl_cmd_t                 cmd,
  output abl_pkg::abl_stat_t                     stat,
  output abl_pkg::abl_out_t                      out_data
);
  import abl_pkg::*;

  localparam logic signed [16:0] A_SLOW_LO = $signed({2'b00, A_SLOW[14:0]});
  localparam logic signed [16:0] A_SLOW_HI = $signed({1'b0, A_SLOW[30:15]});
  localparam logic signed [16:0] A_FAST_LO = $signed({2'b00, A_FAST[14:0]});
  localparam logic signed [16:0] A_FAST_HI = $signed({1'b0, A_FAST[30:15]});

  // Configuration registers.
  logic [11:0] sens_r;
  logic [15:0] smooth_r;
  logic        src_sel_r;

  // Architectural state.
  logic signed [31:0] slow_r;
  logic signed [31:0] fast_r;
  logic [SUM_W-1:0]   sum_r;
  logic [15:0]        peak_r;
  logic [CNT_W-1:0]   count_r;
  logic [24:0]        floor_r;
  logic [24:0]        ceil_r;
  logic [15:0]        peak_avg_r;
  logic [15:0]        bass_avg_r;

  // Working registers.
  logic signed [15:0] sample_r;
  logic               last_r;
  logic signed [49:0] pl_s_r, pl_f_r, ph_s_r, ph_f_r;
  logic signed [15:0] bass_r;
  logic [30:0]        sq_r;
  logic [48:0]        sq_v_r;
  logic [49:0]        sq_root_r;
  logic [48:0]        sq_bit_r;
  logic [23:0]        rms_r;
  logic [56:0]        cm1_r, fm1_r;
  logic [47:0]        cm2_r, fm2_r;
  logic [31:0]        po_r, bo_r;
  logic [32:0]        px_r, bx_r;
  logic [27:0]        lm_r;
  abl_out_t           out_r;

  // Combinational helpers.
  logic signed [32:0] s30;
  logic signed [32:0] d_s, d_f;
  logic signed [65:0] full_s, full_f;
  logic signed [32:0] band;
  logic signed [17:0] band_q;
  logic signed [15:0] bass_sat;
  logic signed [31:0] sq_full;
  logic [15:0]        mag;
  logic [49:0]        sq_trial;
  logic [23:0]        rms;
  logic [57:0]        csum, fsum;
  logic [24:0]        ndiff;
  logic [15:0]        w;
  logic [16:0]        wc;
  logic [15:0]        norm16;
  logic [15:0]        pk16;
  logic [32:0]        psum, bsum;
  logic [11:0]        sens;
  logic [15:0]        sig;
  logic [15:0]        level;
  logic               div_start;
  logic [DIVN_W-1:0]  div_num;
  logic [DEN_W-1:0]   div_den;
  logic [5:0]         div_shift;
  logic [QUO_W-1:0]   div_quo;
  logic               div_done;

  // Filter differences against the Q1.30 sample.
  assign s30    = {{2{sample_r[15]}}, sample_r, 15'd0};
  assign d_s    = s30 - {slow_r[31], slow_r};
  assign d_f    = s30 - {fast_r[31], fast_r};
  assign full_s = (66'(ph_s_r) <<< 15) + 66'(pl_s_r);
  assign full_f = (66'(ph_f_r) <<< 15) + 66'(pl_f_r);

  // Bass band in Q1.15 with saturation.
  assign band   = {fast_r[31], fast_r} - {slow_r[31], slow_r};
  assign band_q = band[32:15];
  always_comb begin
    if (band_q[17:15] == 3'b000 || band_q[17:15] == 3'b111) begin
      bass_sat = band_q[15:0];
    end else if (band_q[17]) begin
      bass_sat = 16'sh8000;
    end else begin
      bass_sat = 16'sh7FFF;
    end
  end
  assign sq_full = bass_r * bass_r;
  assign mag     = sample_r[15] ? (~sample_r + 16'd1) : sample_r;

  // Root step and saturated RMS.
  assign sq_trial = sq_root_r + {1'b0, sq_bit_r};
  assign rms      = (sq_root_r > 50'(RMS_MAX)) ? RMS_MAX : sq_root_r[23:0];

  // Range blends with rounding.
  assign csum = 58'(cm1_r) + 58'(cm2_r) + 58'h0_0000_8000_0000;
  assign fsum = 58'(fm1_r) + 58'(fm2_r) + 58'h0_0000_8000_0000;
  assign ndiff = ({1'b0, rms_r} > floor_r) ? ({1'b0, rms_r} - floor_r) : '0;

  // Smoothing weights, normalized bass and doubled peak.
  assign w      = (smooth_r > SMOOTH_MAX) ? SMOOTH_MAX : smooth_r;
  assign wc     = 17'h1_0000 - {1'b0, w};
  assign norm16 = (div_quo > QUO_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
  assign pk16   = peak_r[15] ? 16'hFFFF : {peak_r[14:0], 1'b0};
  assign psum   = 33'(po_r) + px_r + 33'd32768;
  assign bsum   = 33'(bo_r) + bx_r + 33'd32768;

  // Level source and gain.
  always_comb begin
    if (sens_r < SENS_MIN) begin
      sens = SENS_MIN;
    end else if (sens_r > SENS_MAX) begin
      sens = SENS_MAX;
    end else begin
      sens = sens_r;
    end
  end
  assign sig   = src_sel_r ? peak_avg_r : bass_avg_r;
  assign level = (lm_r[27:24] != 4'd0) ? 16'hFFFF : lm_r[23:8];

  // Shared divider: block mean square, then normalization.
  assign div_start = (cmd.op == OP_DIV1_START) || (cmd.op == OP_NORM_START);
  always_comb begin
    if (cmd.op == OP_DIV1_START) begin
      div_num   = DIVN_W'({sum_r, 18'd0});
      div_den   = DEN_W'(count_r);
      div_shift = DIV1_SHIFT;
    end else begin
      div_num   = DIVN_W'({ndiff, 16'd0});
      div_den   = ceil_r - floor_r;
      div_shift = NORM_SHIFT;
    end
  end

  abl_div #(
    .NUM_W (DIVN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .shift (div_shift),
    .quo   (div_quo),
    .done  (div_done)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r    <= SENS_RESET;
      smooth_r  <= SMOOTH_RESET;
      src_sel_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SENSITIVITY) begin
        sens_r <= cfg_wdata[11:0];
      end
      if (cfg_index == CFG_SMOOTHING) begin
        smooth_r <= cfg_wdata;
      end
      if (cfg_index == CFG_SOURCE_SELECT) begin
        src_sel_r <= cfg_wdata[0];
      end
    end
  end

  // Architectural state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_r     <= '0;
      fast_r     <= '0;
      sum_r      <= '0;
      peak_r     <= '0;
      count_r    <= '0;
      floor_r    <= FLOOR_RESET;
      ceil_r     <= CEIL_RESET;
      peak_avg_r <= '0;
      bass_avg_r <= '0;
    end else begin
      unique case (cmd.op)
        OP_FUPD: begin
          slow_r <= slow_r + full_s[61:30];
          fast_r <= fast_r + full_f[61:30];
        end
        OP_ACC: begin
          sum_r   <= sum_r + SUM_W'(sq_r);
          count_r <= count_r + CNT_W'(1);
          if (mag > peak_r) begin
            peak_r <= mag;
          end
        end
        OP_RANGE_UPD: begin
          ceil_r  <= ({1'b0, rms_r} > ceil_r) ? {1'b0, rms_r} : csum[56:32];
          floor_r <= ({1'b0, rms_r} < floor_r) ? {1'b0, rms_r} : fsum[56:32];
        end
        OP_SPAN: begin
          if (ceil_r < floor_r + MIN_SPAN) begin
            ceil_r <= floor_r + MIN_SPAN;
          end
        end
        OP_BLEND_UPD: begin
          peak_avg_r <= psum[31:16];
          bass_avg_r <= bsum[31:16];
        end
        OP_OUT_LOAD: begin
          sum_r   <= '0;
          peak_r  <= '0;
          count_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        sample_r <= in_data.sample;
        last_r   <= in_data.last;
      end
      OP_FLO: begin
        pl_s_r <= d_s * A_SLOW_LO;
        pl_f_r <= d_f * A_FAST_LO;
      end
      OP_FHI: begin
        ph_s_r <= d_s * A_SLOW_HI;
        ph_f_r <= d_f * A_FAST_HI;
      end
      OP_BASS: bass_r <= bass_sat;
      OP_SQ:   sq_r   <= sq_full[30:0];
      OP_SQRT_START: begin
        sq_v_r    <= div_quo;
        sq_root_r <= '0;
        sq_bit_r  <= {1'b1, 48'd0};
      end
      OP_SQRT_STEP: begin
        if ({1'b0, sq_v_r} >= sq_trial) begin
          sq_v_r    <= sq_v_r - sq_trial[48:0];
          sq_root_r <= (sq_root_r >> 1) + {1'b0, sq_bit_r};
        end else begin
          sq_root_r <= sq_root_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_RANGE_MUL: begin
        rms_r <= rms;
        cm1_r <= ceil_r * CEIL_KEEP;
        cm2_r <= rms * CEIL_W;
        fm1_r <= floor_r * FLOOR_KEEP;
        fm2_r <= rms * FLOOR_W;
      end
      OP_BLEND_MUL: begin
        po_r <= peak_avg_r * w;
        px_r <= pk16 * wc;
        bo_r <= bass_avg_r * w;
        bx_r <= norm16 * wc;
      end
      OP_LVL_MUL: lm_r <= sig * sens;
      OP_OUT_LOAD: begin
        out_r.level          <= level;
        out_r.peak_smoothed  <= peak_avg_r;
        out_r.bass_smoothed  <= bass_avg_r;
        out_r.block_bass_rms <= rms_r;
      end
      default: begin
      end
    endcase
  end

  // Status to the sequencer.
  assign stat.close     = last_r || (count_r == CNT_W'(MAX_BLOCK - 1));
  assign stat.div_done  = div_done;
  assign stat.sqrt_last = sq_bit_r[0];
  assign out_data       = out_r;

`ifndef SYNTHESIS
  // The range keeps its minimum span whenever it is used to normalize.
  a_span_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_NORM_START) |-> (ceil_r >= floor_r + MIN_SPAN))
    else $error("ceiling closer to floor than the minimum span");

  // RMS never exceeds the ceiling, so the normalized quotient stays at or below one.
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_BLEND_MUL) |-> (div_quo <= QUO_W'(17'h1_0000)))
    else $error("normalized bass above full scale");

  // The sample count never passes the block limit.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_BLOCK)
    else $error("block count beyond the limit");
`endif

endmodule

`default_nettype wire

// File: src/audio_bass_level_tracker_unit.sv
// Each sample is loaded, filtered in two multiply steps and an update, then
// banded, squared and accumulated; a block-closing sample also runs the 49-step
// shift-subtract divider, the 25-step square root and the 17-step normalize.
// A new sample is taken only when idle; the result waits in an output register.
// Reset: rst_n is synchronous, active low, and restores registers, filters,
// accumulators, floor, ceiling and averages to their initial values.
`default_nettype none

// ----------------------------------------------------------------------------
// audio_bass_level_tracker_unit: adaptive bass envelope follower
// Band-passes samples, measures bass RMS and peak per block, and reports a
// normalized, smoothed and gain-scaled level once per block.
// ----------------------------------------------------------------------------
module audio_bass_level_tracker_unit #(
  parameter int MAX_BLOCK = 4096,
  parameter int RATE_HZ   = 48000
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire abl_pkg::abl_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output abl_pkg::abl_out_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire logic [abl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [abl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import abl_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W  = CNT_W + 30;
  localparam int DIVN_W = SUM_W + 18;

  // Filter coefficients at 40 Hz and 180 Hz for this sample rate.
  localparam logic [63:0] X_SLOW = Q30_TWO_PI * 64'd40 / 64'(RATE_HZ);
  localparam logic [63:0] X_FAST = Q30_TWO_PI * 64'd180 / 64'(RATE_HZ);
  localparam logic [63:0] C_SLOW = q30_coeff(X_SLOW);
  localparam logic [63:0] C_FAST = q30_coeff(X_FAST);
  localparam logic [30:0] A_SLOW = C_SLOW[30:0];
  localparam logic [30:0] A_FAST = C_FAST[30:0];

  abl_cmd_t  cmd;
  abl_stat_t stat;

  abl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  abl_dp #(
    .MAX_BLOCK (MAX_BLOCK),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .DIVN_W    (DIVN_W),
    .A_SLOW    (A_SLOW),
    .A_FAST    (A_FAST)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bass level tracker
// Drives sample blocks with bursty valid and a stalling receiver, predicts
// each untyped block result with an in-bench fixed-point model of the filters, the
// RMS, the adaptive range and the smoothing, and compares each field.
// ----------------------------------------------------------------------------
module tb;
  import abl_pkg::*;

  localparam int BLOCK_LIMIT = 4096;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  abl_in_t in_data;
  logic out_valid;
  logic out_ready;
  abl_out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  audio_bass_level_tracker_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Directed stimulus row; want is used only where typed is set.
  typedef struct {
    logic signed [15:0] smp;
    bit                 lst;
    bit                 typed;
    abl_out_t           want;
  } dir_row_t;

  // Predicted register copies and tracker state.
  logic [11:0] gain_reg;
  logic [15:0] weight_reg;
  logic        src_reg;
  longint lp_slow, lp_fast, coef_slow, coef_fast;
  longint unsigned sq_sum, blk_peak, blk_count, rng_floor, rng_ceil, peak_lvl, bass_lvl;

  abl_out_t level_results[$];
  int errors;
  int shown;
  int rdy_mode;
  int rdy_cnt;

  // One-pole coefficient 1 - exp(-2*pi*f/rate) in Q0.30 by alternating series.
  function automatic longint pole_coeff(input longint unsigned freq);
    longint unsigned x;
    longint unsigned t;
    longint acc;
    x = 64'd6746518852 * freq / 64'd48000;
    if (x > 64'h1_0000_0000) x = 64'h1_0000_0000;
    t = x;
    acc = 0;
    for (int k = 1; k <= 12; k++) begin
      if (k > 1) t = (t * x / longint'(k)) >> 30;
      if (k % 2 == 1) acc = acc + longint'(t);
      else acc = acc - longint'(t);
    end
    return acc;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mix(input longint unsigned old, input longint unsigned x,
                                          input longint unsigned w);
    return (old * w + x * (64'd65536 - w) + 64'd32768) >> 16;
  endfunction

  function automatic void reset_tracker();
    gain_reg = SENS_RESET;
    weight_reg = SMOOTH_RESET;
    src_reg = 1'b0;
    lp_slow = 0;
    lp_fast = 0;
    sq_sum = 0;
    blk_peak = 0;
    blk_count = 0;
    rng_floor = 33554;
    rng_ceil = 1006633;
    peak_lvl = 0;
    bass_lvl = 0;
  endfunction

  // Advance the tracker by one sample; a closed block yields one result.
  function automatic bit track_sample(input abl_in_t it, output abl_out_t res);
    longint s, s30, bass;
    longint unsigned q, rms, norm, pk, w, gain, sig, lvl;
    s = longint'($signed(it.sample));
    s30 = s * 32768;
    lp_slow = lp_slow + (((s30 - lp_slow) * coef_slow) >>> 30);
    lp_fast = lp_fast + (((s30 - lp_fast) * coef_fast) >>> 30);
    bass = (lp_fast - lp_slow) >>> 15;
    if (bass > 32767) bass = 32767;
    if (bass < -32768) bass = -32768;
    sq_sum = sq_sum + longint'(bass * bass);
    if ((s < 0 ? -s : s) > longint'(blk_peak)) blk_peak = (s < 0 ? -s : s);
    blk_count++;
    res = '0;
    if (!it.last && blk_count < BLOCK_LIMIT) return 1'b0;

    q = (sq_sum << 18) / blk_count;
    rms = int_sqrt(q);
    if (rms > 64'd16777215) rms = 64'd16777215;

    // Adapt the ceiling and floor, then keep a minimum span between them.
    if (rms > rng_ceil) rng_ceil = rms;
    else rng_ceil = (rng_ceil * ((64'd1 << 32) - 64'd8589935) + rms * 64'd8589935
                     + (64'd1 << 31)) >> 32;
    if (rms < rng_floor) rng_floor = rms;
    else rng_floor = (rng_floor * ((64'd1 << 32) - 64'd2147484) + rms * 64'd2147484
                      + (64'd1 << 31)) >> 32;
    if (rng_ceil < rng_floor + 64'd67109) rng_ceil = rng_floor + 64'd67109;

    if (rms <= rng_floor) begin
      norm = 0;
    end else begin
      norm = ((rms - rng_floor) << 16) / (rng_ceil - rng_floor);
      if (norm > 65535) norm = 65535;
    end

    pk = blk_peak * 2;
    if (pk > 65535) pk = 65535;
    w = (weight_reg > SMOOTH_MAX) ? SMOOTH_MAX : weight_reg;
    peak_lvl = mix(peak_lvl, pk, w);
    bass_lvl = mix(bass_lvl, norm, w);

    gain = (gain_reg < SENS_MIN) ? SENS_MIN : ((gain_reg > SENS_MAX) ? SENS_MAX : gain_reg);
    sig = src_reg ? peak_lvl : bass_lvl;
    lvl = (sig * gain) >> 8;
    if (lvl > 65535) lvl = 65535;

    res.level = lvl[15:0];
    res.peak_smoothed = peak_lvl[15:0];
    res.bass_smoothed = bass_lvl[15:0];
    res.block_bass_rms = rms[23:0];
    sq_sum = 0;
    blk_peak = 0;
    blk_count = 0;
    return 1'b1;
  endfunction

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: check each result transfer and stall on a shifting pattern.
  always @(posedge clk) begin
    abl_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (level_results.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result %h", out_data);
        end
      end else begin
        want = level_results.pop_front();
        if (out_data.level !== want.level || out_data.peak_smoothed !== want.peak_smoothed ||
            out_data.bass_smoothed !== want.bass_smoothed ||
            out_data.block_bass_rms !== want.block_bass_rms) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("mismatch: level %0d/%0d peak %0d/%0d bass %0d/%0d rms %0d/%0d",
                     want.level, out_data.level, want.peak_smoothed, out_data.peak_smoothed,
                     want.bass_smoothed, out_data.bass_smoothed,
                     want.block_bass_rms, out_data.block_bass_rms);
          end
        end
      end
    end
    rdy_cnt++;
    if (rdy_cnt >= 64) begin
      rdy_cnt = 0;
      rdy_mode = $urandom_range(0, 3);
    end
    case (rdy_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= (rdy_cnt % 8) < 3;
      default: out_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Write one register and mirror it into the predicted copies.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SENSITIVITY:   gain_reg = val[11:0];
      CFG_SMOOTHING:     weight_reg = val;
      CFG_SOURCE_SELECT: src_reg = val[0];
      default: ;
    endcase
  endtask

  // Present one sample and hold it until the transfer; then maybe idle.
  task automatic send_sample(input abl_in_t it, input bit typed, input abl_out_t want,
                             input int gap);
    abl_out_t res;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (track_sample(it, res)) level_results.push_back(typed ? want : res);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  int burst_left;

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 12);
    return $urandom_range(1, 9);
  endfunction

  // Stop sending, wait for every pending result, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (level_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Random block with an amplitude of its own so the range tracker moves.
  task automatic send_block(input int len);
    abl_in_t it;
    int amp;
    int base;
    amp = 1 << $urandom_range(4, 16);
    base = $urandom_range(0, 1) ? int'($urandom_range(0, 65535)) - 32768 : 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) it.sample = 16'($urandom);
      else it.sample = 16'(base + int'($urandom_range(0, amp - 1)) - amp / 2);
      it.last = (i == len - 1);
      send_sample(it, 1'b0, '0, next_gap());
    end
  endtask

  dir_row_t dir_rows[$];

  initial begin
    dir_row_t row;
    abl_in_t it;
    int n;
    errors = 0;
    shown = 0;
    rdy_mode = 0;
    rdy_cnt = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    coef_slow = pole_coeff(40);
    coef_fast = pole_coeff(180);
    reset_tracker();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a silent one-sample block gives all zeros, then extremes.
    row = '{smp: 16'sd0, lst: 1'b1, typed: 1'b1, want: '0};
    dir_rows.push_back(row);
    row.typed = 1'b0;
    for (int i = 0; i < 6; i++) begin
      row.smp = 16'sh7fff;
      row.lst = (i == 5);
      dir_rows.push_back(row);
    end
    row.smp = -16'sd32768; row.lst = 1'b0; dir_rows.push_back(row);
    row.smp = -16'sd32768; row.lst = 1'b1; dir_rows.push_back(row);
    row.smp = 16'sd1;      row.lst = 1'b0; dir_rows.push_back(row);
    row.smp = -16'sd1;     row.lst = 1'b1; dir_rows.push_back(row);
    for (int i = 0; i < 8; i++) begin
      row.smp = (i % 2) ? -16'sd32768 : 16'sh7fff;
      row.lst = (i == 7);
      dir_rows.push_back(row);
    end
    row.smp = 16'sd0; row.lst = 1'b1; dir_rows.push_back(row);
    foreach (dir_rows[i]) begin
      it.sample = dir_rows[i].smp;
      it.last = dir_rows[i].lst;
      send_sample(it, dir_rows[i].typed, dir_rows[i].want, next_gap());
    end

    // Overlong block: closes by itself on the last allowed sample.
    for (int i = 0; i < BLOCK_LIMIT; i++) begin
      it.sample = 16'($urandom);
      it.last = 1'b0;
      send_sample(it, 1'b0, '0, 0);
    end
    drain();

    // Register settings, extremes and out-of-range values among them.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin write_reg(CFG_SENSITIVITY, 16'd26); write_reg(CFG_SMOOTHING, 16'd0); end
        1: begin write_reg(CFG_SENSITIVITY, 16'd2560); write_reg(CFG_SMOOTHING, 16'd64225); end
        2: begin write_reg(CFG_SOURCE_SELECT, 16'd1); write_reg(CFG_SENSITIVITY, 16'd4095); end
        3: begin write_reg(CFG_SENSITIVITY, 16'd0); write_reg(CFG_SMOOTHING, 16'hffff); end
        4: begin write_reg(CFG_SOURCE_SELECT, 16'hfffe); write_reg(3, 16'hffff); end
        5: begin write_reg(CFG_SENSITIVITY, 16'hf3ff); write_reg(CFG_SMOOTHING, 16'd32768); end
        default: begin
          write_reg(CFG_SENSITIVITY, 16'($urandom_range(0, 65535)));
          write_reg(CFG_SMOOTHING, 16'($urandom_range(0, 65535)));
          write_reg(CFG_SOURCE_SELECT, 16'($urandom_range(0, 65535)));
        end
      endcase
      n = 0;
      while (n < 100) begin
        it.sample = 0;
        if ($urandom_range(0, 19) == 0) begin
          send_block($urandom_range(40, 80));
          n += 60;
        end else begin
          send_block($urandom_range(1, 16));
          n += 8;
        end
      end
      drain();
    end

    repeat (150) @(posedge clk);
    if (errors == 0 && level_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
